[src/wpdt_pkg.sv]
// Shared types, constants and helpers for the weather packet decoder.
// This package has no dependencies. Every other file in src imports it.
`default_nettype none

package wpdt_pkg;

  // Sensor table geometry.
  localparam int TABLE_DEPTH = 8;
  localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TBL_CW = $clog2(TABLE_DEPTH + 1);

  // Decoded packet kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_SYNC = 2'd1;
  localparam logic [1:0] KIND_GEN  = 2'd2;

  // Table outcomes.
  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_ADDED   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NODEC   = 2'd3;

  // Packet format constants.
  localparam logic [3:0]         SYNC_NIBBLE = 4'hA;
  localparam logic [7:0]         SYNC_MIN_LEN = 8'd8;
  localparam logic [7:0]         GEN_MIN_LEN  = 8'd4;
  localparam logic [7:0]         GEN_HUM_LEN  = 8'd5;
  localparam logic signed [11:0] GEN_TEMP_MIN = -12'sd400;
  localparam logic signed [11:0] GEN_TEMP_MAX = 12'sd600;
  localparam logic [6:0]         BAT_LOW = 7'd10;
  localparam logic [6:0]         BAT_OK  = 7'd100;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        id;
    logic signed [11:0] temp;
    logic [7:0]         hum;
    logic [6:0]         bat;
  } dec_t;

  typedef struct packed {
    logic        start;
    logic        clear;
    logic [15:0] id;
  } tbl_req_t;

  typedef struct packed {
    logic              done;
    logic [1:0]        status;
    logic [TBL_AW-1:0] slot;
    logic [TBL_CW-1:0] count;
  } tbl_res_t;

  function automatic logic [2:0] fit_slot(input logic [TBL_AW-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[2:0];
  endfunction

  function automatic logic [3:0] fit_count(input logic [TBL_CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[3:0];
  endfunction

endpackage

`default_nettype wire

[src/wpdt_decode.sv]
// Field decoder for one packet word: sync-nibble and generic formats.
// Depends on wpdt_pkg. Purely combinational.
`default_nettype none

module wpdt_decode
  import wpdt_pkg::*;
(
  input  wire logic [63:0] pkt_bytes,
  input  wire logic [7:0]  pkt_len,
  output dec_t             dec
);

  logic [7:0]         b0, b1, b2, b3, b4, b5, b6, b7;
  logic [10:0]        mag;
  logic signed [11:0] sync_temp;
  logic signed [11:0] gen_temp;
  logic               is_sync;
  logic               gen_ok;

  assign b0 = pkt_bytes[63:56];
  assign b1 = pkt_bytes[55:48];
  assign b2 = pkt_bytes[47:40];
  assign b3 = pkt_bytes[39:32];
  assign b4 = pkt_bytes[31:24];
  assign b5 = pkt_bytes[23:16];
  assign b6 = pkt_bytes[15:8];
  assign b7 = pkt_bytes[7:0];

  // BCD digits are weighted as they stand, so non-decimal nibbles pass through.
  assign mag = 11'(b5[3:0]) * 11'd100 + 11'(b6[7:4]) * 11'd10 + 11'(b6[3:0]);
  assign sync_temp = b5[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign gen_temp  = $signed({b2[3:0], b3});

  assign is_sync = (pkt_len >= SYNC_MIN_LEN) && (b0[7:4] == SYNC_NIBBLE);
  assign gen_ok  = (pkt_len >= GEN_MIN_LEN) && (gen_temp >= GEN_TEMP_MIN)
                   && (gen_temp <= GEN_TEMP_MAX);

  always_comb begin
    dec = '0;
    if (is_sync) begin
      dec.kind = KIND_SYNC;
      dec.id   = {b0[3:0], b1, b2[7:4]};
      dec.temp = sync_temp;
      dec.hum  = 8'(b7[7:4]) * 8'd10 + 8'(b7[3:0]);
      dec.bat  = b4[2] ? BAT_LOW : BAT_OK;
    end else if (gen_ok) begin
      dec.kind = KIND_GEN;
      dec.id   = {b0, b1};
      dec.temp = gen_temp;
      dec.hum  = (pkt_len >= GEN_HUM_LEN) ? {1'b0, b4[6:0]} : 8'd0;
      dec.bat  = BAT_OK;
    end
  end

endmodule

`default_nettype wire

[src/wpdt_table.sv]
// Sensor id table with a sequencer that compares one entry per cycle.
// Depends on wpdt_pkg.
`default_nettype none

module wpdt_table
  import wpdt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tbl_req_t          req,
  output tbl_res_t               res,
  output logic [TBL_CW-1:0]      used
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state;
  logic [TBL_CW-1:0] used_count;
  logic [TBL_CW-1:0] ptr;
  logic [15:0]       key;
  logic [15:0]       id_table [TABLE_DEPTH];
  logic              more;
  logic              room;
  logic              hit;

  assign used = used_count;
  assign more = (ptr < used_count);
  assign room = (used_count < TBL_CW'(TABLE_DEPTH));
  assign hit  = more && (id_table[ptr[TBL_AW-1:0]] == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      ptr        <= '0;
      res        <= '0;
    end else begin
      res.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.clear) begin
            used_count <= '0;
          end else if (req.start) begin
            key   <= req.id;
            ptr   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res.done   <= 1'b1;
            res.status <= ST_UPDATED;
            res.slot   <= ptr[TBL_AW-1:0];
            res.count  <= used_count;
            state      <= S_IDLE;
          end else if (more) begin
            ptr <= ptr + 1'b1;
          end else if (room) begin
            res.done   <= 1'b1;
            res.status <= ST_ADDED;
            res.slot   <= used_count[TBL_AW-1:0];
            res.count  <= used_count + 1'b1;
            used_count <= used_count + 1'b1;
            state      <= S_IDLE;
          end else begin
            res.done   <= 1'b1;
            res.status <= ST_FULL;
            res.slot   <= '0;
            res.count  <= used_count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new id goes to the first free entry once the scan finds no match.
  always_ff @(posedge clk) begin
    if (state == S_SCAN && !more && room) begin
      id_table[used_count[TBL_AW-1:0]] <= key;
    end
  end

endmodule

`default_nettype wire

[src/weather_packet_decode_table_top.sv]
// Top level of the weather packet decoder: input handshake, decode register,
// table sequencer and output register. Depends on wpdt_pkg, wpdt_decode, wpdt_table.
//
//   channel | handshake          | payload
//   in      | in_valid/in_ready  | req_type, pkt_valid, pkt_bytes, pkt_len
//   out     | out_valid/out_ready| kind, sensor_id, temp_tenths, humidity,
//           |                    | battery_pct, table_status, slot, sensor_count
//
// A decoded packet goes from acceptance through the decode register, the table scan
// (one table entry passed over per cycle until a match) and the output register.
// An undecoded packet skips the table scan and goes to the output register; clears
// and invalid packets give none and leave the input ready on the next cycle.
// Reset empties the table and drops any pending result word. A result word held
// by out_ready low stalls only the final step; the next input word is accepted meanwhile.
`default_nettype none

module weather_packet_decode_table_top
  import wpdt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               req_type,
  input  wire logic               pkt_valid,
  input  wire logic [63:0]        pkt_bytes,
  input  wire logic [7:0]         pkt_len,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              kind,
  output logic [15:0]             sensor_id,
  output logic signed [11:0]      temp_tenths,
  output logic [7:0]              humidity,
  output logic [6:0]              battery_pct,
  output logic [1:0]              table_status,
  output logic [2:0]              slot,
  output logic [3:0]              sensor_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t            state;
  dec_t              dec;
  dec_t              dec_q;
  logic [1:0]        status_q;
  logic [2:0]        slot_q;
  logic [3:0]        count_q;
  tbl_req_t          treq;
  tbl_res_t          tres;
  logic [TBL_CW-1:0] used;
  logic              in_fire;
  logic              pkt_fire;

  wpdt_decode u_decode (
    .pkt_bytes (pkt_bytes),
    .pkt_len   (pkt_len),
    .dec       (dec)
  );

  wpdt_table u_table (
    .clk  (clk),
    .rst  (rst),
    .req  (treq),
    .res  (tres),
    .used (used)
  );

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pkt_fire = in_fire && !req_type && pkt_valid;

  assign treq.start = pkt_fire && (dec.kind != KIND_NONE);
  assign treq.clear = in_fire && req_type;
  assign treq.id    = dec.id;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pkt_fire) begin
            dec_q <= dec;
            if (dec.kind != KIND_NONE) begin
              state <= S_WAIT;
            end else begin
              status_q <= ST_NODEC;
              slot_q   <= 3'd0;
              count_q  <= fit_count(used);
              state    <= S_EMIT;
            end
          end
        end
        S_WAIT: begin
          if (tres.done) begin
            status_q <= tres.status;
            slot_q   <= fit_slot(tres.slot);
            count_q  <= fit_count(tres.count);
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            kind         <= dec_q.kind;
            sensor_id    <= dec_q.id;
            temp_tenths  <= dec_q.temp;
            humidity     <= dec_q.hum;
            battery_pct  <= dec_q.bat;
            table_status <= status_q;
            slot         <= slot_q;
            sensor_count <= count_q;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for weather_packet_decode_table_top: directed and random packet words,
// checked against a behavioral decoder with its own sensor id table.
// Depends on wpdt_pkg and the RTL under src.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wpdt_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        id;
    logic signed [11:0] temp;
    logic [7:0]         hum;
    logic [6:0]         bat;
    logic [1:0]         status;
    logic [2:0]         slot;
    logic [3:0]         count;
  } reading_t;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = 1'b0;
  logic               pkt_valid = 1'b0;
  logic [63:0]        pkt_bytes = '0;
  logic [7:0]         pkt_len = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic [15:0]        sensor_id;
  logic signed [11:0] temp_tenths;
  logic [7:0]         humidity;
  logic [6:0]         battery_pct;
  logic [1:0]         table_status;
  logic [2:0]         slot;
  logic [3:0]         sensor_count;

  // Predictor state: ids seen so far and how many table entries are in use.
  logic [15:0] seen_ids [TABLE_DEPTH];
  int          seen_count = 0;
  reading_t    pending_readings [$];
  reading_t    want;
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b1;

  weather_packet_decode_table_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .pkt_valid(pkt_valid), .pkt_bytes(pkt_bytes), .pkt_len(pkt_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .sensor_id(sensor_id), .temp_tenths(temp_tenths), .humidity(humidity),
    .battery_pct(battery_pct), .table_status(table_status), .slot(slot),
    .sensor_count(sensor_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decodes one accepted word and updates the id table. Returns 1 when a
  // result word is due.
  function automatic bit decode_reading(input bit rq, input bit pv, input logic [63:0] by,
                                        input logic [7:0] ln, output reading_t r);
    logic [7:0]  b [8];
    logic [11:0] raw;
    int          mag;
    int          t;
    int          hit_slot;
    r = '0;
    r.kind = KIND_NONE;
    r.status = ST_NODEC;
    if (rq) begin
      seen_count = 0;
      return 1'b0;
    end
    if (!pv) return 1'b0;
    for (int i = 0; i < 8; i++) b[i] = by[63 - 8 * i -: 8];

    if (ln >= 8 && b[0][7:4] == SYNC_NIBBLE) begin
      mag = int'(b[5][3:0]) * 100 + int'(b[6][7:4]) * 10 + int'(b[6][3:0]);
      r.kind = KIND_SYNC;
      r.id = {b[0][3:0], b[1], b[2][7:4]};
      r.temp = 12'(b[5][7] ? -mag : mag);
      r.hum = 8'(int'(b[7][7:4]) * 10 + int'(b[7][3:0]));
      r.bat = b[4][2] ? BAT_LOW : BAT_OK;
    end else if (ln >= 4) begin
      raw = {b[2][3:0], b[3]};
      t = raw[11] ? int'(raw) - 4096 : int'(raw);
      if (t >= -400 && t <= 600) begin
        r.kind = KIND_GEN;
        r.id = {b[0], b[1]};
        r.temp = 12'(t);
        r.hum = (ln >= 5) ? {1'b0, b[4][6:0]} : 8'd0;
        r.bat = BAT_OK;
      end
    end

    if (r.kind != KIND_NONE) begin
      hit_slot = -1;
      for (int i = 0; i < seen_count; i++) begin
        if (hit_slot < 0 && seen_ids[i] == r.id) hit_slot = i;
      end
      if (hit_slot >= 0) begin
        r.status = ST_UPDATED;
        r.slot = 3'(hit_slot);
      end else if (seen_count < TABLE_DEPTH) begin
        seen_ids[seen_count] = r.id;
        r.status = ST_ADDED;
        r.slot = 3'(seen_count);
        seen_count++;
      end else begin
        r.status = ST_FULL;
      end
    end
    r.count = 4'(seen_count);
    return 1'b1;
  endfunction

  // Presents one word, holds it until accepted, and records the expected result.
  // Valid is only lowered when an idle cycle is inserted.
  task automatic send_word(input bit rq, input bit pv, input logic [63:0] by,
                           input logic [7:0] ln);
    reading_t r;
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    pkt_valid <= pv;
    pkt_bytes <= by;
    pkt_len <= ln;
    do @(posedge clk); while (!in_ready);
    if (decode_reading(rq, pv, by, ln, r)) pending_readings.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side: check each result word, then choose the next ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual kind %h id %h",
                 $time, kind, sensor_id);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        compare_field("kind", 16'(want.kind), 16'(kind));
        compare_field("sensor_id", want.id, sensor_id);
        compare_field("temp_tenths", 16'(want.temp), 16'(temp_tenths));
        compare_field("humidity", 16'(want.hum), 16'(humidity));
        compare_field("battery_pct", 16'(want.bat), 16'(battery_pct));
        compare_field("table_status", 16'(want.status), 16'(table_status));
        compare_field("slot", 16'(want.slot), 16'(slot));
        compare_field("sensor_count", 16'(want.count), 16'(sensor_count));
      end
    end
    out_ready <= idle_on ? ($urandom_range(99) >= 30) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_directed();
    send_word(1'b1, 1'b1, '1, 8'hFF);                           // clear with busy payload
    send_word(1'b0, 1'b0, 64'hA123_4567_89AB_CDEF, 8'd8);       // invalid packet
    send_word(1'b0, 1'b1, 64'hAFFF_FFFF_FFFF_FFFF, 8'd255);     // sync, largest negative
    send_word(1'b0, 1'b1, 64'hA000_0000_0000_0000, 8'd8);       // sync, all zero
    send_word(1'b0, 1'b1, 64'hAFFF_F000_0005_9999, 8'd8);       // sync, same id updated
    send_word(1'b0, 1'b1, 64'hA000_0100_FF00_0000, 8'd7);       // sync nibble, too short
    send_word(1'b0, 1'b1, 64'h1234_FE70_FF00_0000, 8'd4);       // generic at -400, no humidity
    send_word(1'b0, 1'b1, 64'h1234_0258_8000_0000, 8'd5);       // generic at 600
    send_word(1'b0, 1'b1, 64'h5555_0E6F_0000_0000, 8'd6);       // just below range
    send_word(1'b0, 1'b1, 64'h5555_0259_0000_0000, 8'd4);       // just above range
    send_word(1'b0, 1'b1, 64'h1234_0100_0000_0000, 8'd3);       // too short for anything
    send_word(1'b0, 1'b1, 64'hA000_0000_0000_0000, 8'd0);
    send_word(1'b0, 1'b1, 64'h0000_0FFF_0000_0000, 8'd4);       // generic at -1
    // Fill the remaining entries, then overflow by one.
    for (int i = 1; i <= 5; i++) begin
      send_word(1'b0, 1'b1, {16'h1000 + 16'(i), 16'h0123, 32'h7F00_0000}, 8'd5);
    end
    send_word(1'b0, 1'b1, 64'hA777_7000_0400_0012, 8'd9);       // new sync id, table full
    send_word(1'b0, 1'b1, 64'h1234_0001_0000_0000, 8'd4);       // known id while full
    send_word(1'b1, 1'b0, 64'h0, 8'd0);
    send_word(1'b0, 1'b0, 64'h1234_0001_0000_0000, 8'd4);
    send_word(1'b0, 1'b1, 64'hBEEF_0001_0000_0000, 8'd4);       // first entry after clear
  endtask

  // Mostly well-formed packets over a small id pool so the table hits, fills
  // and gets cleared, with some noise, invalid words and clears mixed in.
  task automatic send_random(input int n);
    logic [15:0] id_pool [12];
    logic [63:0] by;
    logic [7:0]  ln;
    logic [15:0] id;
    int          pick;
    int          t;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      by = {$urandom, $urandom};
      ln = 8'($urandom);
      id = ($urandom_range(7) == 0) ? 16'($urandom) : id_pool[$urandom_range(11)];
      if (pick < 4) begin
        send_word(1'b1, 1'($urandom), by, ln);
      end else if (pick < 12) begin
        send_word(1'b0, 1'b0, by, ln);
      end else if (pick < 20) begin
        send_word(1'b0, 1'b1, by, ln);
      end else if (pick < 60) begin
        by[63:60] = SYNC_NIBBLE;
        by[59:44] = id;
        ln = ($urandom_range(3) == 0) ? 8'd8 : 8'($urandom_range(255, 8));
        send_word(1'b0, 1'b1, by, ln);
      end else begin
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: t = -400;
            1: t = 600;
            2: t = -401;
            default: t = 601;
          endcase
        end else begin
          t = int'($urandom_range(1000)) - 400;
        end
        by[63:48] = id;
        by[43:32] = 12'(t);
        case ($urandom_range(3))
          0: ln = 8'd4;
          1: ln = 8'd5;
          default: ln = 8'($urandom_range(255, 4));
        endcase
        send_word(1'b0, 1'b1, by, ln);
      end
    end
  endtask

  task automatic test_random_idle();
    idle_on = 1'b1;
    send_random(1550);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_random(400);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_random_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
